// ===== src/bmd_pkg.sv =====
package bmd_pkg;

    // field widths
    localparam int IDX_W    = 7;
    localparam int VAL_W    = 64;

    // digit-serial datapath: two bits per cycle
    localparam int DIG_W    = 2;
    localparam int PROD_W   = 72;                 // 64 x 7 product, padded to whole digits
    localparam int PROD_DIG = PROD_W / DIG_W;     // digits per multiply or divide pass
    localparam int CNT_W    = $clog2(PROD_DIG);

    // packed stream widths
    localparam int S_DATA_W = 16;

    // controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

endpackage

// ===== src/binomial_multiply_divide_unit.sv =====
// Channel  | Ports          | Beat contents (low bit first)
// ---------+----------------+----------------------------------------------
// input    | s_tvalid/ready | s_tdata: row_n[6:0], pick_m[13:7], zero pad
// result   | m_tvalid/ready | m_tdata: coefficient[63:0]; m_tuser: overflow
//
// One pair is worked at a time. Each step d = 2..min(m, n-m) runs a serial
// multiply pass and a serial exact-divide pass (2 bits per cycle through a
// 72-bit shift register). A saturating row stops at the step that overflows,
// so the longest items are rows n = 66 or 67 near the middle, with 32 steps;
// trivial pairs run no steps.
// aresetn is synchronous, active low, and clears the controller and valid.
// The result sits in an output register; a new pair is taken while it waits,
// and a finished result holds in its state until the register is free.
module binomial_multiply_divide_unit #(
    parameter int MAX_ROW = 128
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bmd_pkg::S_DATA_W-1:0]  s_tdata,   // row_n[6:0], pick_m[13:7]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bmd_pkg::VAL_W-1:0]     m_tdata,   // coefficient[63:0]
    output logic                          m_tuser    // overflow[0]
);

    localparam int IW = bmd_pkg::IDX_W;
    localparam int DW = bmd_pkg::DIG_W;
    localparam int PW = bmd_pkg::PROD_W;
    localparam int VW = bmd_pkg::VAL_W;
    localparam int CW = bmd_pkg::CNT_W;

    bmd_pkg::state_t state_reg, state_next;

    logic [IW-1:0] n_reg, n_next;
    logic [IW-1:0] lim_reg, lim_next;
    logic [IW-1:0] d_reg, d_next;
    logic [IW-1:0] acc_reg, acc_next;
    logic [IW-1:0] rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] val_reg, val_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic          ovf_reg, ovf_next;

    logic          out_valid_reg, out_valid_next;
    logic [VW-1:0] out_data_reg, out_data_next;
    logic          out_ovf_reg, out_ovf_next;

    // input unpacking and trivial-case decode
    logic [IW-1:0] in_n, in_m, in_diff, in_lim;
    logic          in_accept;

    assign in_n      = s_tdata[IW-1:0];
    assign in_m      = s_tdata[2*IW-1:IW];
    assign in_diff   = in_n - in_m;
    assign in_lim    = (in_m > in_diff) ? in_diff : in_m;
    assign s_tready  = (state_reg == bmd_pkg::ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // multiply digit: acc + digit * f, f = n - d + 1
    logic [IW-1:0]    fac;
    logic [IW+DW-1:0] mul_sum;

    assign fac     = n_reg - d_reg + IW'(1);
    assign mul_sum = (IW+DW)'(acc_reg) + (IW+DW)'(val_reg[DW-1:0]) * (IW+DW)'(fac);

    // divide digit: DW restoring steps on the top product bits
    logic [IW-1:0] div_rem;
    logic [DW-1:0] div_q;

    always_comb begin
        logic [IW:0] r;
        div_rem = rem_reg;
        div_q   = '0;
        for (int i = 0; i < DW; i++) begin
            r = {div_rem, prod_reg[PW-1-i]};
            if (r >= {1'b0, d_reg}) begin
                div_rem         = IW'(r - {1'b0, d_reg});
                div_q[DW-1-i]   = 1'b1;
            end else begin
                div_rem         = r[IW-1:0];
            end
        end
    end

    logic          last_cnt;
    logic          out_free;
    logic [PW-1:0] quot;

    assign last_cnt = (cnt_reg == CW'(bmd_pkg::PROD_DIG - 1));
    assign out_free = !out_valid_reg || m_tready;
    assign quot     = {prod_reg[PW-DW-1:0], div_q};

    // controller and datapath next state
    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        lim_next       = lim_reg;
        d_next         = d_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        val_next       = val_reg;
        prod_next      = prod_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_ovf_next   = out_ovf_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bmd_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_next   = in_n;
                    lim_next = in_lim;
                    d_next   = IW'(2);
                    acc_next = '0;
                    cnt_next = '0;
                    ovf_next = 1'b0;
                    if (in_m > in_n || {1'b0, in_n} >= (IW+1)'(MAX_ROW)) begin
                        val_next   = '0;
                        state_next = bmd_pkg::ST_FIN;
                    end else if (in_n == '0 || in_m == '0 || in_m == in_n) begin
                        val_next   = VW'(1);
                        state_next = bmd_pkg::ST_FIN;
                    end else begin
                        val_next   = VW'(in_n);
                        state_next = (in_lim < IW'(2)) ? bmd_pkg::ST_FIN : bmd_pkg::ST_MUL;
                    end
                end
            end

            bmd_pkg::ST_MUL: begin
                // product shifts in from the top, value drains from the bottom
                prod_next = {mul_sum[DW-1:0], prod_reg[PW-1:DW]};
                acc_next  = mul_sum[IW+DW-1:DW];
                val_next  = {{DW{1'b0}}, val_reg[VW-1:DW]};
                cnt_next  = cnt_reg + CW'(1);
                if (last_cnt) begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = bmd_pkg::ST_DIV;
                end
            end

            bmd_pkg::ST_DIV: begin
                // product leaves at the top, quotient enters at the bottom
                prod_next = quot;
                rem_next  = div_rem;
                cnt_next  = cnt_reg + CW'(1);
                if (last_cnt) begin
                    cnt_next = '0;
                    acc_next = '0;
                    if (quot[PW-1:VW] != '0) begin
                        val_next   = '1;
                        ovf_next   = 1'b1;
                        state_next = bmd_pkg::ST_FIN;
                    end else begin
                        val_next = quot[VW-1:0];
                        if (d_reg == lim_reg) begin
                            state_next = bmd_pkg::ST_FIN;
                        end else begin
                            d_next     = d_reg + IW'(1);
                            state_next = bmd_pkg::ST_MUL;
                        end
                    end
                end
            end

            bmd_pkg::ST_FIN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = val_reg;
                    out_ovf_next   = ovf_reg;
                    state_next     = bmd_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = bmd_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bmd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        lim_reg      <= lim_next;
        d_reg        <= d_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        val_reg      <= val_next;
        prod_reg     <= prod_next;
        ovf_reg      <= ovf_next;
        out_data_reg <= out_data_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ovf_reg;

endmodule
